@@ hdl/fdf_pkg.sv @@
`default_nettype none

package fdf_pkg;

    localparam int VALUE_W          = 32;
    localparam int LEN_W            = 5;
    localparam int FRAC_W           = 4;
    localparam int POS_W            = 4;
    localparam int CHAR_W           = 8;
    localparam int MAX_FIELD_LENGTH = 16;
    localparam int NUM_DIGITS       = 10;
    // Signed width for the position arithmetic; covers -64..63.
    localparam int SW               = 7;

    localparam logic [LEN_W-1:0]  TOTAL_LENGTH_RESET    = 5'd8;
    localparam logic [FRAC_W-1:0] FRACTION_DIGITS_RESET = 4'd0;

    localparam logic REG_TOTAL_LENGTH    = 1'b0;
    localparam logic REG_FRACTION_DIGITS = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

    // Picks one BCD digit; any index outside the row reads as zero.
    function automatic logic [3:0] digit_at(digit_vec_t d, logic [SW-1:0] idx);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (idx == SW'(i))
            begin
                r = d[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fixed_point_decimal_formatter_top.sv @@
// Formats an unsigned 32-bit value with a sign flag into a right-aligned ASCII field of
// total_length characters (at most 16) with fraction_digits digits after a decimal point.
// A request is taken when start is high and busy is low. The value is loaded into a row of
// ten BCD digit cells and shifted through them bit by bit, the ST_PREP state then sizes the
// integer part, and then the field comes out one character per cycle from position 0 on,
// each marked by strobe for a single cycle, with last on the rightmost one. The receiver
// cannot stall the output, so it must take every strobed character. With a length of zero a
// request produces nothing and busy never rises. Write configuration only while busy is low.
`default_nettype none

module fixed_point_decimal_formatter_top (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [fdf_pkg::VALUE_W-1:0]       value,
    input  wire                              negative,
    input  wire                              write_enable,
    input  wire                              write_index,
    input  wire [fdf_pkg::LEN_W-1:0]         write_data,
    output logic                             strobe,
    output logic [fdf_pkg::CHAR_W-1:0]       character,
    output logic [fdf_pkg::POS_W-1:0]        position,
    output logic                             last
);
    import fdf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]  total_length_reg;
    logic [FRAC_W-1:0] fraction_digits_reg;

    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  len_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              neg_reg;
    logic signed [SW-1:0] start_pos_reg, start_pos_next;
    logic [LEN_W-1:0]  ndig_reg, ndig_next;

    logic              strobe_reg, strobe_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg, last_next;

    logic [LEN_W-1:0]  len_eff;
    logic              accept;
    chain_ctrl_t       ctrl;
    digit_vec_t        digits;

    assign len_eff = (total_length_reg > LEN_W'(MAX_FIELD_LENGTH))
                     ? LEN_W'(MAX_FIELD_LENGTH) : total_length_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;

    assign ctrl.load  = accept;
    assign ctrl.shift = (state_reg == ST_CONV);

    fdf_bcd_chain u_chain (
        .clk    (clk),
        .ctrl   (ctrl),
        .value  (value),
        .digits (digits)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg    <= TOTAL_LENGTH_RESET;
            fraction_digits_reg <= FRACTION_DIGITS_RESET;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_TOTAL_LENGTH:    total_length_reg    <= write_data;
                REG_FRACTION_DIGITS: fraction_digits_reg <= write_data[FRAC_W-1:0];
                default:             ;
            endcase
        end
    end

    // Integer part sizing, evaluated once the digit cells have settled.
    logic [3:0]           top_idx;
    logic                 any_digit;
    logic                 int_nonzero;
    logic [LEN_W-1:0]     int_digits;
    logic signed [SW-1:0] len_s, frac_s;

    assign len_s  = signed'(SW'(len_reg));
    assign frac_s = signed'(SW'(frac_reg));

    always_comb
    begin
        top_idx   = 4'd0;
        any_digit = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                top_idx   = 4'(i);
                any_digit = 1'b1;
            end
        end
        int_nonzero = any_digit && (top_idx >= frac_reg);
        int_digits  = LEN_W'(top_idx) - LEN_W'(frac_reg) + LEN_W'(1);

        // The rightmost integer digit sits just left of the point, and the same
        // figure caps how many integer digits fit.
        if (frac_reg != '0)
        begin
            start_pos_next = len_s - frac_s - SW'(2);
        end
        else
        begin
            start_pos_next = len_s - SW'(1);
        end

        if (!int_nonzero)
        begin
            ndig_next = LEN_W'(1);
        end
        else if (start_pos_next <= 0)
        begin
            ndig_next = '0;
        end
        else if (start_pos_next < signed'(SW'(int_digits)))
        begin
            ndig_next = start_pos_next[LEN_W-1:0];
        end
        else
        begin
            ndig_next = int_digits;
        end
    end

    // Character for the current position.
    logic [POS_W-1:0]     k;
    logic signed [SW-1:0] k_s;
    logic signed [SW-1:0] e_s;
    logic signed [SW-1:0] ndig_s;
    logic                 in_frac;
    logic                 at_point;

    assign k        = cnt_reg[POS_W-1:0];
    assign k_s      = signed'(SW'(k));
    assign e_s      = start_pos_reg - k_s;
    assign ndig_s   = signed'(SW'(ndig_reg));
    assign in_frac  = (frac_reg != '0) && (k_s >= (len_s - frac_s));
    assign at_point = (frac_reg != '0) && (k_s == (len_s - SW'(1) - frac_s));

    always_comb
    begin
        if (in_frac)
        begin
            char_next = CH_ZERO + CHAR_W'(digit_at(digits, len_s - SW'(1) - k_s));
        end
        else if (at_point)
        begin
            char_next = CH_POINT;
        end
        else if ((e_s >= 0) && (e_s < ndig_s))
        begin
            char_next = CH_ZERO + CHAR_W'(digit_at(digits, frac_s + e_s));
        end
        else if (neg_reg && (e_s == ndig_s))
        begin
            char_next = CH_MINUS;
        end
        else
        begin
            char_next = CH_SPACE;
        end
    end

    assign last_next = (cnt_reg == (len_reg - LEN_W'(1)));

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (len_eff != '0))
                begin
                    state_next = ST_CONV;
                    cnt_next   = '0;
                end
            end
            ST_CONV:
            begin
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg == LEN_W'(VALUE_W - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                cnt_next    = cnt_reg + LEN_W'(1);
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg  <= len_eff;
            frac_reg <= fraction_digits_reg;
            neg_reg  <= negative;
        end
        if (state_reg == ST_PREP)
        begin
            start_pos_reg <= start_pos_next;
            ndig_reg      <= ndig_next;
        end
        if (state_reg == ST_EMIT)
        begin
            char_reg <= char_next;
            pos_reg  <= k;
            last_reg <= last_next;
        end
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign position  = pos_reg;
    assign last      = strobe_reg && last_reg;

    // A field starts at position zero in the cycle after the first emit cycle.
    a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == ST_PREP, 2) |-> (strobe && position == '0))
        else $error("first character not at position zero");

    // Characters of one field come at consecutive positions without gaps.
    a_next_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && position == $past(position) + POS_W'(1)))
        else $error("character sequence broken");

    // After the last character the block is free for a new request.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("still busy after last character");

    // A request with a nonzero length always starts a conversion.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && len_eff != '0) |=> (state_reg == ST_CONV && cnt_reg == '0))
        else $error("request with nonzero length not started");

endmodule

`default_nettype wire

@@ hdl/fdf_bcd_cell.sv @@
`default_nettype none

module fdf_bcd_cell (
    input  wire                       clk,
    input  wire fdf_pkg::chain_ctrl_t ctrl,
    input  wire                       shift_in,
    output logic                      shift_out,
    output logic [3:0]                digit
);
    import fdf_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add three before the shift so that the digit carries at ten.
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign shift_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[2:0], shift_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

@@ hdl/fdf_bcd_chain.sv @@
`default_nettype none

module fdf_bcd_chain (
    input  wire                            clk,
    input  wire fdf_pkg::chain_ctrl_t      ctrl,
    input  wire [fdf_pkg::VALUE_W-1:0]     value,
    output fdf_pkg::digit_vec_t            digits
);
    import fdf_pkg::*;

    logic [VALUE_W-1:0]  bin_reg;
    logic [VALUE_W-1:0]  bin_next;
    logic [NUM_DIGITS:0] carry;

    always_comb
    begin
        bin_next = bin_reg;
        if (ctrl.load)
        begin
            bin_next = value;
        end
        else if (ctrl.shift)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
    end

    assign carry[0] = bin_reg[VALUE_W-1];

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        fdf_bcd_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .shift_in  (carry[i]),
            .shift_out (carry[i+1]),
            .digit     (digits[i])
        );
    end

endmodule

`default_nettype wire
